### src/fbat_pkg.sv
// fbat_pkg: shared types and constants for the flow byte accounting table
// no dependencies
`default_nettype none
package fbat_pkg;

  localparam int MAC_W   = 48;
  localparam int IP_W    = 32;
  localparam int LEN_W   = 16;
  localparam int TIME_W  = 32;
  localparam int BYTES_W = 32;
  localparam int TOTAL_W = 40;
  localparam int IVL_W   = 16;
  localparam int CFG_W   = 40;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START     = 2'd2;

  localparam logic [TOTAL_W-1:0] THRESHOLD_RESET = 40'd1048576;
  localparam logic [IVL_W-1:0]   INTERVAL_RESET  = 16'd5;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_ENTRY  = 1'b1;

  // one result beat
  typedef struct packed {
    logic               kind;
    logic [MAC_W-1:0]   mac;
    logic [IP_W-1:0]    ip;
    logic [BYTES_W-1:0] bytes;
    logic               warn;
    logic               drop;
    logic               last;
  } result_t;

endpackage
`default_nettype wire

### src/fbat_store.sv
// fbat_store: entry memory (key and byte count), one write and one read port
// depends on fbat_pkg
`default_nettype none
module fbat_store #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic [AW-1:0]               wr_addr,
  input  wire logic [fbat_pkg::MAC_W-1:0]  wr_mac,
  input  wire logic [fbat_pkg::IP_W-1:0]   wr_ip,
  input  wire logic [fbat_pkg::BYTES_W-1:0] wr_bytes,
  input  wire logic [AW-1:0]               rd_addr,
  output logic      [fbat_pkg::MAC_W-1:0]  rd_mac,
  output logic      [fbat_pkg::IP_W-1:0]   rd_ip,
  output logic      [fbat_pkg::BYTES_W-1:0] rd_bytes
);
  import fbat_pkg::*;

  logic [MAC_W+IP_W+BYTES_W-1:0] mem [DEPTH];

  // synchronous write, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_mac, wr_ip, wr_bytes};
    end
    {rd_mac, rd_ip, rd_bytes} <= mem[rd_addr];
  end
endmodule
`default_nettype wire

### src/flow_byte_accounting_table_top.sv
// flow_byte_accounting_table_top: per-flow byte accounting table, top level
// depends on fbat_pkg and fbat_store
//
// Input beats carry a frame key (mac, ip), a length and a timestamp; output
// beats carry one status result per frame, optionally followed by a dump of
// every table entry in insertion order when the interval has elapsed.
// Configuration is a plain write port: 0 threshold, 1 interval, 2 start time.
// The table is scanned entry by entry (read, then compare) through the
// single read port of the entry memory; a frame that misses goes through
// the scan, a final append (a drop if the table is full) and the status
// step, and a hit stops the scan at its entry and goes to the status step.
// A dump reads and then outputs each entry, and waits while the
// receiver stalls. One frame is handled at a time; the output register
// holds a beat until taken. The next frame may be taken and scanned while a
// beat waits, but the status and dump steps wait on a stall.
// Reset clears the entry count, running total and registers to defaults;
// the first frame after reset loads the interval start from start_time.
// Entry memory contents need no clearing: only entries below the count are
// ever read.
`default_nettype none
module flow_byte_accounting_table_top #(
  parameter int TABLE_ENTRIES = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [47:0]                   in_mac_key,
  input  wire logic [31:0]                   in_ip_key,
  input  wire logic [15:0]                   in_frame_length,
  input  wire logic [31:0]                   in_time_seconds,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_result_kind,
  output logic      [47:0]                   out_entry_mac,
  output logic      [31:0]                   out_entry_ip,
  output logic      [31:0]                   out_entry_bytes,
  output logic                               out_over_warning,
  output logic                               out_table_full_drop,
  output logic                               out_last_of_run,
  input  wire logic                          cfg_we,
  input  wire logic [fbat_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fbat_pkg::CFG_W-1:0]    cfg_wdata
);
  import fbat_pkg::*;

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] FULL = CW'(TABLE_ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_CMP, S_STATUS, S_DUMP_RD, S_DUMP_OUT
  } state_t;

  // configuration registers
  logic [TOTAL_W-1:0] thr_r;
  logic [IVL_W-1:0]   ivl_r;
  logic [TIME_W-1:0]  start_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= THRESHOLD_RESET;
      ivl_r   <= INTERVAL_RESET;
      start_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD: thr_r   <= cfg_wdata;
        REG_INTERVAL:  ivl_r   <= cfg_wdata[IVL_W-1:0];
        REG_START:     start_r <= cfg_wdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  state_t             state_r;
  logic [CW-1:0]      count_r;
  logic [TOTAL_W-1:0] total_r;
  logic [TIME_W-1:0]  istart_r;
  logic               started_r;
  logic [CW-1:0]      idx_r;
  logic [MAC_W-1:0]   mac_r;
  logic [IP_W-1:0]    ip_r;
  logic [LEN_W-1:0]   len_r;
  logic [TIME_W-1:0]  now_r;
  logic               drop_r;
  logic               warn_r;
  result_t            res_r;
  logic               ovalid_r;

  // memory ports
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [BYTES_W-1:0] wr_bytes;
  logic [AW-1:0]      rd_addr;
  logic [MAC_W-1:0]   rd_mac;
  logic [IP_W-1:0]    rd_ip;
  logic [BYTES_W-1:0] rd_bytes;

  fbat_store #(.DEPTH(TABLE_ENTRIES), .AW(AW)) u_store (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_mac   (mac_r),
    .wr_ip    (ip_r),
    .wr_bytes (wr_bytes),
    .rd_addr  (rd_addr),
    .rd_mac   (rd_mac),
    .rd_ip    (rd_ip),
    .rd_bytes (rd_bytes)
  );

  // compare and saturating adds
  logic               hit;
  logic [BYTES_W:0]   esum;
  logic [TOTAL_W:0]   tsum;
  logic [TOTAL_W-1:0] tsat;
  logic [TIME_W-1:0]  elapsed;
  logic               out_free;
  logic               res_load;

  assign hit      = (rd_mac == mac_r) && (rd_ip == ip_r);
  assign esum     = {1'b0, rd_bytes} + (BYTES_W+1)'(len_r);
  assign tsum     = {1'b0, total_r} + (TOTAL_W+1)'(len_r);
  assign tsat     = tsum[TOTAL_W] ? '1 : tsum[TOTAL_W-1:0];
  assign elapsed  = now_r - istart_r;
  assign out_free = !ovalid_r || out_ready;
  assign res_load = out_free && (state_r == S_STATUS || state_r == S_DUMP_OUT);
  assign in_ready = (state_r == S_IDLE);
  assign rd_addr  = idx_r[AW-1:0];

  // write on a hit (update) or at the end of the scan (append, if not full)
  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = idx_r[AW-1:0];
    wr_bytes = BYTES_W'(len_r);
    if (state_r == S_CMP && hit) begin
      wr_en    = 1'b1;
      wr_bytes = esum[BYTES_W] ? '1 : esum[BYTES_W-1:0];
    end else if (state_r == S_SCAN && idx_r == count_r && count_r != FULL) begin
      wr_en = 1'b1;
    end
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      total_r   <= '0;
      started_r <= 1'b0;
      ovalid_r  <= 1'b0;
      istart_r  <= '0;
    end else begin
      // output register: loaded by status or dump, emptied when taken
      if (res_load) ovalid_r <= 1'b1;
      else if (out_ready) ovalid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            mac_r  <= in_mac_key;
            ip_r   <= in_ip_key;
            len_r  <= in_frame_length;
            now_r  <= in_time_seconds;
            idx_r  <= '0;
            drop_r <= 1'b0;
            if (!started_r) begin
              istart_r  <= start_r;
              started_r <= 1'b1;
            end
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          // read of idx_r issued this cycle; compare next
          if (idx_r == count_r) begin
            if (count_r == FULL) drop_r <= 1'b1;
            else count_r <= count_r + 1'b1;
            state_r <= S_STATUS;
          end else begin
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          if (hit) begin
            state_r <= S_STATUS;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_SCAN;
          end
        end
        S_STATUS: begin
          if (out_free) begin
            total_r        <= tsat;
            res_r.kind     <= KIND_STATUS;
            res_r.mac      <= '0;
            res_r.ip       <= '0;
            res_r.bytes    <= '0;
            res_r.warn     <= (tsat >= thr_r);
            res_r.drop     <= drop_r;
            warn_r         <= (tsat >= thr_r);
            res_r.last     <= !((elapsed >= TIME_W'(ivl_r)) && count_r != '0);
            idx_r          <= '0;
            if (elapsed >= TIME_W'(ivl_r)) begin
              istart_r <= now_r;
              state_r  <= (count_r != '0) ? S_DUMP_RD : S_IDLE;
              if (count_r == '0) count_r <= '0;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_DUMP_RD: begin
          state_r <= S_DUMP_OUT;
        end
        S_DUMP_OUT: begin
          if (out_free) begin
            res_r.kind  <= KIND_ENTRY;
            res_r.mac   <= rd_mac;
            res_r.ip    <= rd_ip;
            res_r.bytes <= rd_bytes;
            res_r.warn  <= warn_r;
            res_r.drop  <= 1'b0;
            res_r.last  <= (idx_r + 1'b1 == count_r);
            if (idx_r + 1'b1 == count_r) begin
              count_r <= '0;
              state_r <= S_IDLE;
            end else begin
              idx_r   <= idx_r + 1'b1;
              state_r <= S_DUMP_RD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid           = ovalid_r;
  assign out_result_kind     = res_r.kind;
  assign out_entry_mac       = res_r.mac;
  assign out_entry_ip        = res_r.ip;
  assign out_entry_bytes     = res_r.bytes;
  assign out_over_warning    = res_r.warn;
  assign out_table_full_drop = res_r.drop;
  assign out_last_of_run     = res_r.last;

  // entry count never exceeds the table size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL) else $error("entry count beyond table size");
  // a dropped key only when the table is full
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && res_r.drop) |-> count_r == FULL)
    else $error("drop with free entries");
  // no new frame taken while a result is still pending in a dump
  a_dump_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DUMP_RD || state_r == S_DUMP_OUT) |-> !in_ready)
    else $error("input taken during dump");
  // the running total never decreases
  a_total_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> total_r >= $past(total_r))
    else $error("running total decreased");

endmodule
`default_nettype wire
